FILE: src/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Types and constants shared by the generational handle table modules.
// ----------------------------------------------------------------------------
package ght_pkg;

	localparam int unsigned PROBE_STRIDE = 256;
	localparam logic [31:0] FREE_EMPTY = 32'hFFFF_FFFF;

	localparam logic [2:0] MODE_NEW_TAG = 3'd0;
	localparam logic [2:0] MODE_ADD = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_FIND = 3'd3;
	localparam logic [2:0] MODE_GET = 3'd4;

	typedef enum logic [2:0] {
		OP_NEW_TAG,
		OP_ADD,
		OP_REMOVE,
		OP_FIND,
		OP_GET,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t op;
		logic [63:0] payload;
		logic [31:0] tag;
		logic [31:0] id;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic hit;
		logic [63:0] payload;
		logic [31:0] tag;
		logic [31:0] id;
	} res_t;

	typedef struct packed {
		logic live;
		logic [31:0] link;
		logic [31:0] tag;
		logic [63:0] payload;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_RD,
		ST_CHK,
		ST_RESP
	} state_t;

endpackage

FILE: src/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// Handle table with a LIFO free list and generation-tagged 32-bit ids.
// ----------------------------------------------------------------------------
// New_tag, unknown modes and a full add go straight to the result state; an add
// writes a fresh slot directly, or first reads a freed slot (one slot memory read)
// for its free list link. Remove and get read and check one slot per probe, then
// a bound check ends a search with no match; at most SLOTS/256 slots are probed.
// Find also scans one slot per probe, up to SLOTS slots; one read port sets this.
// A two-word queue takes new requests while the back end works or a result waits.
// Reset empties queue and free list, zeroes used, sets the id counter to 1; RAM is kept.
module generational_handle_table import ght_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [127:0] s_tdata, // payload_in, tag_in, id_in
	input  logic [2:0] s_tuser,   // mode
	output logic m_tvalid,
	input  logic m_tready,
	output logic [127:0] m_tdata, // id_out, tag_out, payload_out
	output logic [1:0] m_tuser    // hit, table_full
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	ght_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	ght_back #(.SLOTS(SLOTS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("Request popped from an empty queue.");

	a_full_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> cmd_valid)
		else $error("Input stalled while the queue is empty.");

	a_pop_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> !cmd_pop)
		else $error("Two requests popped in consecutive cycles.");

endmodule

FILE: src/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/ght_front.sv
// ----------------------------------------------------------------------------
// ght_front
// Accepts request words, decodes the mode and queues them in a two-entry FIFO.
// ----------------------------------------------------------------------------
module ght_front import ght_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [127:0] s_tdata, // payload_in, tag_in, id_in
	input  logic [2:0] s_tuser,   // mode
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_pop
);

	cmd_t fifo_q [2];
	logic [1:0] cnt_q;
	logic wr_q;
	logic rd_q;
	logic push;
	cmd_t dec;

	always_comb begin
		dec.payload = s_tdata[63:0];
		dec.tag = s_tdata[95:64];
		dec.id = s_tdata[127:96];
		unique case (s_tuser)
			MODE_NEW_TAG: dec.op = OP_NEW_TAG;
			MODE_ADD: dec.op = OP_ADD;
			MODE_REMOVE: dec.op = OP_REMOVE;
			MODE_FIND: dec.op = OP_FIND;
			MODE_GET: dec.op = OP_GET;
			default: dec.op = OP_NONE;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: src/ght_back.sv
// ----------------------------------------------------------------------------
// ght_back
// Executes queued requests against the slot memory and registers the result.
// ----------------------------------------------------------------------------
module ght_back import ght_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [127:0] m_tdata, // id_out, tag_out, payload_out
	output logic [1:0] m_tuser    // hit, table_full
);

	localparam int AW = $clog2(SLOTS);
	localparam int UW = $clog2(SLOTS + 1);
	localparam int PW = UW + 1;
	localparam int EW = $bits(entry_t);

	state_t state_q, state_d;
	cmd_t cmd_q, cmd_d;
	logic [PW-1:0] ptr_q, ptr_d;
	logic [UW-1:0] used_q, used_d;
	logic [31:0] free_q, free_d;
	logic [31:0] ctr_q, ctr_d;
	res_t res_q, res_d;
	res_t out_q;
	logic out_valid_q;
	logic out_load;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t ram_wentry;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	entry_t rd_e;
	logic free_ok;
	logic room;
	logic id_match;
	logic find_match;

	ght_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(EW'(ram_wentry)),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_e = entry_t'(ram_rdata);
	assign free_ok = free_q < 32'(used_q);
	assign room = used_q < UW'(SLOTS);
	assign id_match = rd_e.live && (rd_e.link == cmd_q.id);
	assign find_match = rd_e.live && (rd_e.tag == cmd_q.tag) && (rd_e.payload == cmd_q.payload);

	always_comb begin
		state_d = state_q;
		cmd_d = cmd_q;
		ptr_d = ptr_q;
		used_d = used_q;
		free_d = free_q;
		ctr_d = ctr_q;
		res_d = res_q;
		cmd_pop = 1'b0;
		out_load = 1'b0;
		ram_we = 1'b0;
		ram_waddr = ptr_q[AW-1:0];
		ram_wentry = '0;
		ram_re = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cmd_d = cmd;
					res_d = '0;
					state_d = ST_RESP;
					unique case (cmd.op)
						OP_NEW_TAG: begin
							res_d.id = ctr_q;
							ctr_d = ctr_q + 32'd1;
						end
						OP_ADD: begin
							if (free_ok) begin
								ram_re = 1'b1;
								ram_raddr = free_q[AW-1:0];
								ptr_d = free_q[PW-1:0];
								state_d = ST_ADD_WR;
							end else if (room) begin
								ram_we = 1'b1;
								ram_waddr = used_q[AW-1:0];
								ram_wentry.live = 1'b1;
								ram_wentry.link = {ctr_q[23:0], used_q[7:0]};
								ram_wentry.tag = cmd.tag;
								ram_wentry.payload = cmd.payload;
								res_d.id = {ctr_q[23:0], used_q[7:0]};
								ctr_d = ctr_q + 32'd1;
								used_d = used_q + UW'(1);
							end else begin
								res_d.full = 1'b1;
							end
						end
						OP_REMOVE, OP_GET: begin
							ptr_d = PW'(cmd.id[7:0]);
							state_d = ST_RD;
						end
						OP_FIND: begin
							ptr_d = '0;
							state_d = ST_RD;
						end
						default: begin
						end
					endcase
				end
			end
			ST_ADD_WR: begin
				ram_we = 1'b1;
				ram_wentry.live = 1'b1;
				ram_wentry.link = {ctr_q[23:0], ptr_q[7:0]};
				ram_wentry.tag = cmd_q.tag;
				ram_wentry.payload = cmd_q.payload;
				res_d.id = {ctr_q[23:0], ptr_q[7:0]};
				ctr_d = ctr_q + 32'd1;
				free_d = rd_e.link;
				state_d = ST_RESP;
			end
			ST_RD: begin
				if (ptr_q >= PW'(used_q)) begin
					state_d = ST_RESP;
				end else begin
					ram_re = 1'b1;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = ST_RD;
				if (cmd_q.op == OP_FIND) begin
					if (find_match) begin
						res_d.id = rd_e.link;
						res_d.hit = 1'b1;
						state_d = ST_RESP;
					end else begin
						ptr_d = ptr_q + PW'(1);
					end
				end else if (id_match) begin
					res_d.hit = 1'b1;
					res_d.payload = rd_e.payload;
					state_d = ST_RESP;
					if (cmd_q.op == OP_GET) begin
						res_d.tag = rd_e.tag;
					end else begin
						ram_we = 1'b1;
						ram_wentry.link = free_q;
						free_d = 32'(ptr_q);
					end
				end else begin
					ptr_d = ptr_q + PW'(PROBE_STRIDE);
				end
			end
			ST_RESP: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			free_q <= FREE_EMPTY;
			ctr_q <= 32'd1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q <= used_d;
			free_q <= free_d;
			ctr_q <= ctr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		ptr_q <= ptr_d;
		res_q <= res_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_q.payload, out_q.tag, out_q.id};
	assign m_tuser = {out_q.full, out_q.hit};

endmodule
